// File: sv/neighbor_table_with_aging_macros.svh
// Assertion macros used by the checker of the neighbor table.
// Depends on a clk_i clock and an rst_ni active-low reset in the using scope.
`ifndef NEIGHBOR_TABLE_WITH_AGING_MACROS_SVH
`define NEIGHBOR_TABLE_WITH_AGING_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NTA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("neighbor table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("neighbor table check failed");

`endif

// File: sv/nta_pkg.sv
// Shared types, codes and constants of the neighbor table with aging.
// Used by the cell, the top level, the checker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package nta_pkg;

  // Default table depth and register reset value.
  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam logic [31:0] MAX_AGE_RST       = 32'd1000;

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 160;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned COUNT_W     = 7;

  // Opcode carried in the input tuser.
  localparam logic OP_BEACON = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_SWEEP    = 3'd4
  } status_e;

  // Command broadcast to every cell.
  typedef enum logic [1:0] {
    CMD_IDLE   = 2'd0,
    CMD_BEACON = 2'd1,
    CMD_SWEEP  = 2'd2,
    CMD_PACK   = 2'd3
  } cmd_e;

  // One stored neighbor entry.
  typedef struct packed {
    logic [31:0] node;
    logic [31:0] sent;
    logic [31:0] recv;
    logic [31:0] data;
  } entry_t;

  // Request fields held while an item is processed.
  typedef struct packed {
    logic [31:0] node;
    logic [31:0] sent;
    logic [31:0] recv;
    logic [31:0] data;
    logic [31:0] now;
  } req_t;

  // Control group from the sequencer to the cells.
  typedef struct packed {
    cmd_e cmd;
    logic any_hit;
  } ctrl_t;

  // Result item, status in the lowest bits.
  typedef struct packed {
    logic [COUNT_W-1:0] occupancy;
    logic [COUNT_W-1:0] removed;
    status_e            status;
  } res_t;

endpackage

// File: sv/nta_cell.sv
// One entry cell of the neighbor table: storage, key match, age test and
// the neighbor exchange used to pack valid entries. Depends on nta_pkg.
`timescale 1ns / 1ps

module nta_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nta_pkg::ctrl_t  ctrl_i,
  input  nta_pkg::req_t   req_i,
  input  logic [31:0]     max_age_i,
  input  logic            ins_sel_i,
  input  logic            pair_lo_i,
  input  logic            left_valid_i,
  input  logic            right_valid_i,
  input  nta_pkg::entry_t right_entry_i,
  output logic            valid_o,
  output nta_pkg::entry_t entry_o,
  output logic            hit_o,
  output logic            older_o
);

  logic            valid_q, valid_d;
  nta_pkg::entry_t entry_q, entry_d;
  logic            match;
  logic            older;
  logic [32:0]     age_sum;
  logic            expire;

  // Key match, send time order and expiry test, all local to this entry.
  always_comb begin
    match   = valid_q && (entry_q.node == req_i.node);
    older   = match && (entry_q.sent > req_i.sent);
    age_sum = {1'b0, entry_q.recv} + {1'b0, max_age_i};
    expire  = valid_q && (age_sum < {1'b0, req_i.now});
  end

  // Next state of the cell for the broadcast command.
  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    case (ctrl_i.cmd)
      nta_pkg::CMD_BEACON: begin
        // The matching entry takes a beacon that is not older; a new key
        // goes to the first free cell, which the sequencer selects.
        if ((match && !older) || (ins_sel_i && !ctrl_i.any_hit)) begin
          valid_d      = 1'b1;
          entry_d.node = req_i.node;
          entry_d.sent = req_i.sent;
          entry_d.recv = req_i.recv;
          entry_d.data = req_i.data;
        end
      end
      nta_pkg::CMD_SWEEP: begin
        if (expire) begin
          valid_d = 1'b0;
        end
      end
      nta_pkg::CMD_PACK: begin
        // Odd-even exchange: a hole below a valid entry swaps with it.
        if (pair_lo_i) begin
          if (!valid_q && right_valid_i) begin
            valid_d = 1'b1;
            entry_d = right_entry_i;
          end
        end else if (!left_valid_i && valid_q) begin
          valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Valid flag is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry contents need no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;
  assign hit_o   = match;
  assign older_o = older;

endmodule

// File: sv/neighbor_table_with_aging.sv
// Top level of the neighbor table with aging: stream ports, sequencer and
// the row of nta_cell entries. Depends on nta_pkg and nta_cell.
`timescale 1ns / 1ps

// Neighbor table keyed by node id, one entry per cell of a row of
// TABLE_ENTRIES cells. Every cell compares its key and tests its age at
// once, and valid entries are always kept packed at the low end of the
// row, so a new key goes to the cell whose index equals the occupancy.
// A beacon (tuser 0) is first registered in S_IDLE, then all cells match
// and write in S_EXEC; a new request is taken only back in S_IDLE. A
// sweep (tuser 1) is registered, the expired entries drop out in S_EXEC,
// and then in S_PACK the cells swap holes upward with their neighbors,
// odd and even pairs in turn, one exchange per cycle, until no hole sits
// below a valid entry. One request is processed at a time; a finished
// result waits in the output register while the next request is taken,
// or in S_HOLD, with no new request taken, while that register is full.
// max_age resets to 1000; the user writes it through cfg_we_i and
// cfg_wdata_i while the block is idle, which the block does not enforce.
module neighbor_table_with_aging #(
  parameter int unsigned TABLE_ENTRIES = nta_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration: max_age.
  input  logic                             cfg_we_i,
  input  logic [31:0]                      cfg_wdata_i,
  // Request stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // node_id [31:0], time_sent [63:32], time_received [95:64],
  // payload [127:96], now_time [159:128]
  input  logic [nta_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // opcode [0]
  input  logic [0:0]                       s_axis_tuser,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status [2:0], removed_count [9:3], occupancy [16:10], zero [23:17]
  output logic [nta_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned OCC_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RES_W = $bits(nta_pkg::res_t);

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_PACK = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic                phase_q;
  logic [OCC_W-1:0]    occ_q;
  logic [31:0]         max_age_q;
  logic                op_q;
  nta_pkg::req_t       req_q;
  nta_pkg::res_t       res_q;
  nta_pkg::res_t       out_q;
  logic                out_valid_q;

  nta_pkg::ctrl_t      ctrl;
  logic                in_fire;
  logic                out_free;

  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic [TABLE_ENTRIES:0]   valid_ext;
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [TABLE_ENTRIES-1:0] older_vec;
  logic [TABLE_ENTRIES-1:0] ins_sel;
  nta_pkg::entry_t          entry_arr [TABLE_ENTRIES];

  logic                any_hit;
  logic                ignored;
  logic                full;
  logic                insert;
  logic                unsorted;
  logic [OCC_W-1:0]    occ_enc;
  logic                fin;
  nta_pkg::res_t       fin_res;
  logic [OCC_W-1:0]    fin_occ;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Row of entry cells with their neighbor links.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic            left_valid;
    logic            right_valid;
    nta_pkg::entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
    end else begin : g_left
      assign left_valid = valid_vec[i-1];
    end

    if (i == TABLE_ENTRIES - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_entry = entry_arr[i];
    end else begin : g_right
      assign right_valid = valid_vec[i+1];
      assign right_entry = entry_arr[i+1];
    end

    assign ins_sel[i] = (occ_q == OCC_W'(i));

    nta_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .req_i         (req_q),
      .max_age_i     (max_age_q),
      .ins_sel_i     (ins_sel[i]),
      .pair_lo_i     (phase_q == 1'(i % 2)),
      .left_valid_i  (left_valid),
      .right_valid_i (right_valid),
      .right_entry_i (right_entry),
      .valid_o       (valid_vec[i]),
      .entry_o       (entry_arr[i]),
      .hit_o         (hit_vec[i]),
      .older_o       (older_vec[i])
    );
  end

  assign valid_ext = {1'b0, valid_vec};

  // Beacon decision; at most one cell can match a key.
  always_comb begin
    any_hit = |hit_vec;
    ignored = |(hit_vec & older_vec);
    full    = (occ_q == OCC_W'(TABLE_ENTRIES));
    insert  = !any_hit && !full;
  end

  // Packing state: holes below valid entries, and the occupancy read off
  // the boundary between the valid run and the empty cells.
  always_comb begin
    unsorted = 1'b0;
    occ_enc  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      unsorted = unsorted || (!valid_ext[i] && valid_ext[i+1]);
      if (valid_ext[i] && !valid_ext[i+1]) begin
        occ_enc = occ_enc | OCC_W'(i + 1);
      end
    end
  end

  // Command to the cells follows the sequencer state.
  always_comb begin
    ctrl.any_hit = any_hit;
    ctrl.cmd     = nta_pkg::CMD_IDLE;
    if (state_q == S_EXEC) begin
      ctrl.cmd = (op_q == nta_pkg::OP_SWEEP) ? nta_pkg::CMD_SWEEP : nta_pkg::CMD_BEACON;
    end else if (state_q == S_PACK) begin
      ctrl.cmd = nta_pkg::CMD_PACK;
    end
  end

  // Result of the request in flight, once its work is complete.
  always_comb begin
    fin             = 1'b0;
    fin_occ         = occ_q;
    fin_res.status  = nta_pkg::ST_SWEEP;
    fin_res.removed = '0;
    if (state_q == S_EXEC && op_q == nta_pkg::OP_BEACON) begin
      fin     = 1'b1;
      fin_occ = occ_q + OCC_W'(insert);
      if (any_hit) begin
        fin_res.status = ignored ? nta_pkg::ST_IGNORED : nta_pkg::ST_UPDATED;
      end else begin
        fin_res.status = full ? nta_pkg::ST_FULL : nta_pkg::ST_INSERTED;
      end
    end else if (state_q == S_PACK && !unsorted) begin
      fin             = 1'b1;
      fin_occ         = occ_enc;
      fin_res.removed = nta_pkg::COUNT_W'(occ_q - occ_enc);
    end
    fin_res.occupancy = nta_pkg::COUNT_W'(fin_occ);
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_q == nta_pkg::OP_SWEEP) begin
          state_d = S_PACK;
        end else begin
          state_d = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_PACK: begin
        if (fin) begin
          state_d = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= 1'b0;
      occ_q       <= '0;
      max_age_q   <= nta_pkg::MAX_AGE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_age_q <= cfg_wdata_i;
      end
      if (state_q == S_PACK) begin
        phase_q <= !phase_q;
      end
      if (fin) begin
        occ_q <= fin_occ;
      end
      if ((fin || state_q == S_HOLD) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, pending result and output payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q      <= s_axis_tuser[0];
      req_q.node <= s_axis_tdata[31:0];
      req_q.sent <= s_axis_tdata[63:32];
      req_q.recv <= s_axis_tdata[95:64];
      req_q.data <= s_axis_tdata[127:96];
      req_q.now  <= s_axis_tdata[159:128];
    end
    if (fin) begin
      res_q <= fin_res;
    end
    if (fin && out_free) begin
      out_q <= fin_res;
    end else if (state_q == S_HOLD && out_free) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(nta_pkg::OUT_TDATA_W - RES_W)'(0), out_q};

endmodule

// File: sv/nta_checker.sv
// Port-level checks of the neighbor table with aging, bound to the top.
// Depends on nta_pkg and neighbor_table_with_aging_macros.svh.
`timescale 1ns / 1ps
`include "neighbor_table_with_aging_macros.svh"

module nta_checker #(
  parameter int unsigned TABLE_ENTRIES = nta_pkg::TABLE_ENTRIES_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [nta_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // Only one request is worked on at a time.
  `NTA_ASSERT_NEXT(a_one_request, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Beacon results never report removed entries.
  `NTA_ASSERT_IMPL(a_beacon_no_removed, m_axis_tvalid && (m_axis_tdata[2:0] != nta_pkg::ST_SWEEP), m_axis_tdata[9:3] == 7'd0)

  // Occupancy never exceeds the table size while it fits the field.
  `NTA_ASSERT_IMPL(a_occ_bound, m_axis_tvalid, (TABLE_ENTRIES > 127) || (m_axis_tdata[16:10] <= TABLE_ENTRIES))

  // A stalled result stays offered and unchanged.
  `NTA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind neighbor_table_with_aging nta_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_nta_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/testbench.sv
// Self-checking testbench for the neighbor table with aging.
// Drives beacon and sweep requests with random bursts, predicts every result in
// the bench and checks the result stream. Depends on nta_pkg and the top level.
`timescale 1ns / 1ps

module testbench;
  import nta_pkg::*;

  localparam int unsigned DEPTH = TABLE_ENTRIES_DEF;

  // One request as the bench sees it, before packing onto the stream.
  typedef struct {
    logic        op;
    logic [31:0] node;
    logic [31:0] sent;
    logic [31:0] recv;
    logic [31:0] data;
    logic [31:0] now;
  } nbr_item_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [31:0]            cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Requests still to be sent and results still to arrive.
  nbr_item_t request_queue[$];
  res_t      awaited_results[$];
  int        mismatch_count = 0;

  // Bench copy of the table and of max_age.
  logic        tbl_valid [DEPTH];
  logic [31:0] tbl_node  [DEPTH];
  logic [31:0] tbl_sent  [DEPTH];
  logic [31:0] tbl_recv  [DEPTH];
  logic [31:0] tbl_data  [DEPTH];
  logic [31:0] age_limit = MAX_AGE_RST;

  neighbor_table_with_aging #(
    .TABLE_ENTRIES(DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply one request to the bench table and return the result it causes.
  function automatic res_t apply_to_table(nbr_item_t it);
    res_t r;
    int   slot;
    bit   hit;
    bit   free_found;
    int   n;
    r.status  = ST_SWEEP;
    r.removed = '0;
    slot       = 0;
    hit        = 1'b0;
    free_found = 1'b0;
    n          = 0;
    if (it.op == OP_BEACON) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (!hit && tbl_valid[i] && tbl_node[i] == it.node) begin
          hit  = 1'b1;
          slot = i;
        end
      end
      if (!hit) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!free_found && !tbl_valid[i]) begin
            free_found = 1'b1;
            slot       = i;
          end
        end
      end
      // A stored entry with a strictly later send time wins.
      if (hit && tbl_sent[slot] > it.sent) begin
        r.status = ST_IGNORED;
      end else if (hit || free_found) begin
        r.status        = hit ? ST_UPDATED : ST_INSERTED;
        tbl_valid[slot] = 1'b1;
        tbl_node[slot]  = it.node;
        tbl_sent[slot]  = it.sent;
        tbl_recv[slot]  = it.recv;
        tbl_data[slot]  = it.data;
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      // Expiry sum is one bit wider so it never wraps.
      for (int i = 0; i < DEPTH; i++) begin
        if (tbl_valid[i] && ({1'b0, tbl_recv[i]} + {1'b0, age_limit}) < {1'b0, it.now}) begin
          tbl_valid[i] = 1'b0;
          r.removed    = r.removed + 1'b1;
        end
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_valid[i]) n++;
    end
    r.occupancy = n[COUNT_W-1:0];
    return r;
  endfunction

  // Queue a beacon; the sweep time field gets random filler.
  task automatic push_beacon(logic [31:0] node, logic [31:0] sent, logic [31:0] recv,
                             logic [31:0] data);
    nbr_item_t it;
    it.op   = OP_BEACON;
    it.node = node;
    it.sent = sent;
    it.recv = recv;
    it.data = data;
    it.now  = $urandom;
    request_queue.push_back(it);
  endtask

  // Queue a sweep; the beacon fields get random filler.
  task automatic push_sweep(logic [31:0] now);
    nbr_item_t it;
    it.op   = OP_SWEEP;
    it.node = $urandom;
    it.sent = $urandom;
    it.recv = $urandom;
    it.data = $urandom;
    it.now  = now;
    request_queue.push_back(it);
  endtask

  // Hold the sender until every result is in, then let the packing pass end.
  task automatic drain_table();
    while (request_queue.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
      @(negedge clk_i);
    repeat (DEPTH + 10) @(posedge clk_i);
  endtask

  task automatic write_max_age(logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    age_limit = value;
  endtask

  // Mostly beacons from a pool of node ids around a drifting time base,
  // with sweeps that reach the expiry edge, plus some fully random requests.
  task automatic random_phase(int count, int pool_size);
    logic [31:0]  id_pool [128];
    logic [31:0]  clock;
    logic [31:0]  tweak;
    int unsigned  reach;
    int unsigned  pick;
    nbr_item_t    it;
    clock = $urandom;
    reach = (age_limit > 32'd1000) ? 1000 : age_limit;
    for (int i = 0; i < pool_size; i++) id_pool[i] = $urandom;
    for (int k = 0; k < count; k++) begin
      clock = clock + 32'($urandom_range(0, 4));
      pick  = $urandom_range(0, 99);
      if (pick < 8) begin
        it.op   = $urandom_range(0, 1);
        it.node = $urandom;
        it.sent = $urandom;
        it.recv = $urandom;
        it.data = $urandom;
        it.now  = $urandom;
        request_queue.push_back(it);
      end else if (pick < 22) begin
        if (age_limit > 32'd1000 && $urandom_range(0, 2) == 0) begin
          push_sweep($urandom);
        end else begin
          push_sweep(clock + 32'($urandom_range(0, 2 * reach + 20)));
        end
      end else begin
        tweak = $urandom_range(0, 8);
        push_beacon(id_pool[$urandom_range(0, pool_size - 1)], clock + tweak - 32'd4,
                    clock + 32'($urandom_range(0, 3)), $urandom);
      end
    end
  endtask

  // Request driver: bursts of random length separated by random gaps.
  nbr_item_t cur_item;
  int        burst_left = 0;
  int        gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(apply_to_table(cur_item));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          cur_item = request_queue.pop_front();
          s_axis_tdata  <= {cur_item.now, cur_item.data, cur_item.recv, cur_item.sent,
                            cur_item.node};
          s_axis_tuser  <= cur_item.op;
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with a receiver stall pattern chosen by the top bits of a free-running counter.
  logic [9:0] stall_cycle = '0;
  res_t       observed;
  res_t       predicted;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_cycle <= stall_cycle + 1'b1;
      case (stall_cycle[9:8])
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= $urandom_range(0, 1);
        2'd2: m_axis_tready <= (stall_cycle[2:0] == 3'd0);
        default: m_axis_tready <= (stall_cycle[4:3] != 2'd3);
      endcase
      if (m_axis_tvalid && m_axis_tready) begin
        observed = res_t'(m_axis_tdata[16:0]);
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result: expected none, got %h", $time, m_axis_tdata);
        end else begin
          predicted = awaited_results.pop_front();
          if (observed.status !== predicted.status) begin
            mismatch_count++;
            $display("%0t: status: expected %0d, got %0d", $time, predicted.status,
                     observed.status);
          end
          if (observed.removed !== predicted.removed) begin
            mismatch_count++;
            $display("%0t: removed_count: expected %0d, got %0d", $time,
                     predicted.removed, observed.removed);
          end
          if (observed.occupancy !== predicted.occupancy) begin
            mismatch_count++;
            $display("%0t: occupancy: expected %0d, got %0d", $time,
                     predicted.occupancy, observed.occupancy);
          end
          if (m_axis_tdata[OUT_TDATA_W-1:17] !== '0) begin
            mismatch_count++;
            $display("%0t: padding: expected 0, got %h", $time,
                     m_axis_tdata[OUT_TDATA_W-1:17]);
          end
        end
      end
    end
  end

  // Stimulus sequence: directed cases, a full-table pass, then random phases.
  initial begin
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed cases at the reset value of max_age.
    push_sweep(32'd0);
    push_beacon(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_beacon(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Equal send time replaces the entry.
    push_beacon(32'h0000_0000, 32'h0000_0000, 32'd10, 32'h0000_1234);
    // Older send time is ignored.
    push_beacon(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd5, 32'h5555_5555);
    // Latest time: the entry received at the top of the range must survive.
    push_sweep(32'hFFFF_FFFF);
    push_beacon(32'd1, 32'd5, 32'd1000, 32'hAAAA_AAAA);
    push_sweep(32'd2000);
    push_sweep(32'd2001);
    push_beacon(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h0F0F_0F0F);
    push_beacon(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    push_beacon(32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    push_sweep(32'h8000_0000);
    push_sweep(32'hFFFF_FFFF);
    drain_table();

    // Fill the table, overflow it, update while full, then age everything out.
    write_max_age(32'd0);
    for (int i = 0; i < DEPTH; i++) begin
      push_beacon(32'h1000_0000 + i, 32'd100, i, $urandom);
    end
    push_beacon(32'h2000_0000, 32'd0, 32'd0, $urandom);
    push_beacon(32'h2000_0001, 32'hFFFF_FFFF, 32'd0, $urandom);
    push_beacon(32'h1000_0003, 32'd100, 32'd3, $urandom);
    push_beacon(32'h1000_0004, 32'd99, 32'd3, $urandom);
    push_sweep(32'd32);
    push_sweep(32'd100);
    push_sweep(32'd0);
    drain_table();

    write_max_age(32'hFFFF_FFFF);
    random_phase(290, 100);
    drain_table();

    write_max_age(32'd37);
    random_phase(290, 48);
    drain_table();

    write_max_age(32'd400);
    random_phase(290, 90);
    drain_table();

    write_max_age(32'h8000_0000);
    random_phase(290, 100);
    drain_table();

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit well above the slowest correct run.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
